/* src/sor_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sor_pkg: shared types and constants of the SOR solver
// Holds the word formats of both channels and the register indexes.
// ----------------------------------------------------------------------------
package sor_pkg;

  localparam int MAX_N = 16;
  localparam int IDX_W = $clog2(MAX_N);
  localparam int CFG_W = 63;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_MAT = 2'd0;
  localparam logic [1:0] KIND_RHS = 2'd1;
  localparam logic [1:0] KIND_GUESS = 2'd2;
  localparam logic [1:0] KIND_START = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAXSW = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               last;
    logic [63:0]        residual;
    logic [15:0]        sweeps_done;
    logic               zero_diagonal;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/sor_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sor_divider: signed restoring divider
// Divides a signed 64-bit dividend by a signed nonzero 32-bit divisor, one
// quotient bit per cycle; truncates toward zero and saturates to 32 bits.
// ----------------------------------------------------------------------------
module sor_divider (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  sor_pkg::div_req_t req_i,
  output sor_pkg::div_rsp_t rsp_o
);
  import sor_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic [32:0] div_q, div_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [64:0] trial;
  logic [64:0] shifted;
  logic [31:0] sat;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; div_d = div_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; neg_d = neg_q;
    shifted = {rem_q, quo_q[63]};
    trial = shifted - {32'd0, div_q};
    if (req_i.start) begin
      neg_d = req_i.dividend[63] ^ req_i.divisor[31];
      quo_d = req_i.dividend[63] ? (64'd0 - req_i.dividend) : req_i.dividend;
      div_d = req_i.divisor[31] ? (33'd0 - {1'b1, req_i.divisor})
                                : {1'b0, req_i.divisor};
      rem_d = '0;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      sat = (quo_q >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo_q[31:0]);
    end else begin
      sat = (quo_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; div_q <= div_d; neg_q <= neg_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = sat;

endmodule
`default_nettype wire

/* src/sor_linear_solver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sor_linear_solver: fixed-point successive over-relaxation solver
// Loads A, b and x0 word by word, then sweeps SOR rows on a start word.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: words of kind matrix, rhs, guess or start. Load words
//   produce nothing. A start word runs sweeps over the n = size_in_use
//   rows and then emits n out words, index 0..n-1, last on the final one,
//   each carrying residual, sweep count and zero-diag flag. One shared
//   34x34 multiplier does every product; each column of a row sum passes
//   through read, multiply and accumulate. A radix-2 divider forms s/a_ii;
//   a row with a zero diagonal skips it. Each out word is read from x and
//   then loaded into the output register. The solve holds in_stall_o high
//   until the last out word is taken.
//   out channel: one output register; while out_stall_i is high the word
//   holds and the sequencer waits.
//   Reset: configuration returns to size 16, tolerance 0, omega 1.0,
//   max sweeps 10000. Stored matrix and vectors are undefined until loaded.
// ----------------------------------------------------------------------------
module sor_linear_solver (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [sor_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [sor_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  sor_pkg::in_word_t            in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output sor_pkg::out_word_t           out_data_o
);
  import sor_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROW, ST_PROD, ST_ACC, ST_DIAG, ST_DIV, ST_STEP, ST_UPD,
    ST_RES, ST_SQ, ST_SWEEP, ST_OUT_RD, ST_OUT, ST_OUT_WAIT
  } state_e;

  // configuration
  logic [4:0]  size_q;
  logic [62:0] tol_q;
  logic [17:0] omega_q;
  logic [15:0] maxsw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 5'd16; tol_q <= '0; omega_q <= 18'd65536; maxsw_q <= 16'd10000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE:  size_q <= cfg_data_i[4:0];
        REG_TOL:   tol_q <= cfg_data_i[62:0];
        REG_OMEGA: omega_q <= cfg_data_i[17:0];
        REG_MAXSW: maxsw_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // active size n, as count 1..MAX_N
  logic [IDX_W:0] n_act;
  always_comb begin
    if (size_q == 5'd0) n_act = (IDX_W+1)'(1);
    else if (32'(size_q) > MAX_N) n_act = (IDX_W+1)'(MAX_N);
    else n_act = (IDX_W+1)'(size_q);
  end
  logic [IDX_W-1:0] n_last;
  assign n_last = IDX_W'(n_act - (IDX_W+1)'(1));

  // memories
  logic signed [31:0] mat_mem [MAX_N*MAX_N];
  logic signed [31:0] rhs_mem [MAX_N];
  logic signed [31:0] x_mem   [MAX_N];

  state_e state_q;
  logic [IDX_W-1:0] i_q, j_q;
  logic signed [63:0] s_q, p_q;
  logic signed [31:0] a_rd_q, x_rd_q, b_rd_q, dg_q, xo_q, q_q, r_q;
  logic [63:0] err_q;
  logic [15:0] done_q;
  logic zd_q;
  logic x_we;
  logic signed [31:0] x_wdata;
  out_word_t out_q;
  logic out_v_q;
  logic out_load;

  wire in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // load the output register when it is empty or its word leaves this cycle
  assign out_load = (state_q == ST_OUT) && (!out_v_q || !out_stall_i);

  // shared multiplier, operands selected by state
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_full;
  always_comb begin
    mul_a = 34'(a_rd_q);
    mul_b = 34'(x_rd_q);
    if (state_q == ST_DIAG) begin
      mul_a = 34'(dg_q);
      mul_b = 34'(xo_q);
    end else if (state_q == ST_STEP) begin
      mul_a = 34'(q_q) - 34'(xo_q);
      mul_b = $signed({16'd0, omega_q});
    end else if (state_q == ST_SQ) begin
      mul_a = 34'(r_q);
      mul_b = 34'(r_q);
    end
  end
  assign mul_full = mul_a * mul_b;

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [64:0] t;
    t = 65'(a) - 65'(b);
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return t[63:0];
  endfunction

  function automatic logic signed [31:0] round_q(logic signed [63:0] v);
    logic signed [64:0] t;
    t = (65'(v) + 65'sd32768) >>> 16;
    if (t > 65'sd2147483647) return 32'sh7FFF_FFFF;
    if (t < -65'sd2147483648) return 32'sh8000_0000;
    return t[31:0];
  endfunction

  div_req_t div_req;
  div_rsp_t div_rsp;
  assign div_req.start = (state_q == ST_DIAG) && (dg_q != 32'sd0);
  assign div_req.dividend = s_q;
  assign div_req.divisor = dg_q;

  sor_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // memory writes / reads
  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.kind == KIND_MAT)
      mat_mem[{in_data_i.row, in_data_i.col}] <= in_data_i.value;
    if (in_acc && in_data_i.kind == KIND_RHS) rhs_mem[in_data_i.row] <= in_data_i.value;
    if (in_acc && in_data_i.kind == KIND_GUESS) x_mem[in_data_i.row] <= in_data_i.value;
    else if (x_we) x_mem[i_q] <= x_wdata;
    a_rd_q <= mat_mem[{i_q, j_q}];
    x_rd_q <= x_mem[j_q];
    b_rd_q <= rhs_mem[i_q];
  end

  logic signed [63:0] step64;
  logic signed [32:0] xsum;
  assign step64 = mul_full[63:0];
  assign xsum = 33'(xo_q) + 33'(round_q(p_q));
  assign x_we = (state_q == ST_UPD) && (dg_q != 32'sd0);
  assign x_wdata = (xsum > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                   (xsum < -33'sd2147483648) ? 32'sh8000_0000 : xsum[31:0];

  logic [63:0] sq_u;
  logic [64:0] err_sum;
  assign sq_u = mul_full[63:0];
  assign err_sum = 65'(err_q) + 65'(sq_u);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; i_q <= '0; j_q <= '0; err_q <= '0; done_q <= '0;
      zd_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (in_acc && in_data_i.kind == KIND_START) begin
          // start: clear counters and open row 0
          i_q <= '0; j_q <= '0; err_q <= '0; done_q <= '0; zd_q <= 1'b0;
          state_q <= ST_ROW;
        end
        ST_ROW: begin
          // reads of row i, column j land next cycle
          state_q <= ST_PROD;
        end
        ST_PROD: begin
          if (j_q == '0) s_q <= 64'(b_rd_q) <<< 16;
          p_q <= mul_full[63:0];
          if (j_q == i_q) begin
            dg_q <= a_rd_q; xo_q <= x_rd_q;
          end
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (j_q != i_q) s_q <= sat_sub(s_q, p_q);
          if (j_q == n_last) begin
            state_q <= ST_DIAG;
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= ST_ROW;
          end
        end
        ST_DIAG: begin
          // take a_ii*x_i on the shared multiplier
          if (dg_q == 32'sd0) begin
            zd_q <= 1'b1;
            state_q <= ST_UPD;
          end else state_q <= ST_DIV;
          p_q <= mul_full[63:0];
        end
        ST_DIV: if (div_rsp.done) begin
          q_q <= div_rsp.quotient;
          s_q <= sat_sub(s_q, p_q);
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          p_q <= step64;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (dg_q == 32'sd0) s_q <= sat_sub(s_q, p_q);
          state_q <= ST_RES;
        end
        ST_RES: begin
          r_q <= round_q(s_q);
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          err_q <= err_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : err_sum[63:0];
          j_q <= '0;
          if (i_q == n_last) begin
            state_q <= ST_SWEEP;
          end else begin
            i_q <= i_q + 1'b1;
            state_q <= ST_ROW;
          end
        end
        ST_SWEEP: begin
          done_q <= done_q + 16'd1;
          i_q <= '0;
          if (err_q > 64'(tol_q) && (done_q + 16'd1) < maxsw_q) begin
            err_q <= '0;
            state_q <= ST_ROW;
          end else state_q <= ST_OUT_RD;
        end
        ST_OUT_RD: begin
          // read of x_j lands next cycle
          state_q <= ST_OUT;
        end
        ST_OUT: if (out_load) begin
          out_q.index <= 4'(j_q);
          out_q.solution <= x_rd_q;
          out_q.last <= (j_q == n_last);
          out_q.residual <= err_q;
          out_q.sweeps_done <= done_q;
          out_q.zero_diagonal <= zd_q;
          if (j_q == n_last) state_q <= ST_OUT_WAIT;
          else begin
            j_q <= j_q + 1'b1;
            state_q <= ST_OUT_RD;
          end
        end
        ST_OUT_WAIT: if (!out_v_q || !out_stall_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire

/* src/sor_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sor_port_checks: port-level checks of the SOR solver
// Watches handshake and result ordering at the top-level ports.
// ----------------------------------------------------------------------------
module sor_port_checks (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input sor_pkg::out_word_t out_data_o
);
  import sor_pkg::*;

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled out word changed");

  // results appear only during a solve
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("out word while input open");

  // a non-final word is followed by the next index
  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last ##1 out_valid_o
    |-> out_data_o.index == $past(out_data_o.index) + 4'd1)
    else $error("out index out of order");

  // at least one sweep is reported
  a_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sweeps_done != 16'd0)
    else $error("zero sweeps reported");

endmodule

bind sor_linear_solver sor_port_checks u_sor_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
`default_nettype wire

/* bench/sor_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sor_checker: prediction and comparison for the SOR solver
// Watches the configuration port and both channels. Every start word is
// solved here in Q16.16, and every out word is compared with the oldest
// predicted word.
// ----------------------------------------------------------------------------
module sor_checker
  import sor_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [CFG_W-1:0]     cfg_data_i,
  input  wire                 in_valid_i,
  input  wire                 in_stall_i,
  input  in_word_t            in_data_i,
  input  wire                 out_valid_i,
  input  wire                 out_stall_i,
  input  out_word_t           out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  words_seen_o
);

  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  int          coeff_mem [MAX_N*MAX_N];
  int          rhs_mem   [MAX_N];
  int          x_mem     [MAX_N];
  logic [4:0]  size_q;
  logic [62:0] tol_q;
  logic [17:0] omega_q;
  logic [15:0] sweep_cap_q;
  out_word_t   solution_fifo [$];

  assign pending_o = solution_fifo.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic longint add_sat(input longint a, input longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Q32.32 down to Q16.16, halves rounded up
  function automatic int to_q16(input longint v);
    longint unsigned mag;
    if (v >= 0) begin
      mag = (longint'(unsigned'(v)) + 64'd32768) >> 16;
      return clamp32(longint'(mag));
    end
    mag = (64'd0 - longint'(unsigned'(v)) + 64'd32767) >> 16;
    return clamp32(-longint'(mag));
  endfunction

  // truncating quotient of a Q32.32 sum by a Q16.16 diagonal
  function automatic int quot_q16(input longint s, input int d);
    logic              neg;
    longint unsigned   ms, md, q;
    neg = (s < 0) != (d < 0);
    ms = (s < 0) ? 64'd0 - longint'(unsigned'(s)) : longint'(unsigned'(s));
    md = (d < 0) ? 64'd0 - longint'(unsigned'(longint'(d))) : longint'(unsigned'(longint'(d)));
    q = ms / md;
    if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : int'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(q);
  endfunction

  task automatic solve_system();
    int unsigned     n, done;
    longint unsigned err, mr, sq;
    logic            zd;
    longint          s, r64, step;
    int              dg, xo, q, r;
    out_word_t       w;
    n = size_q;
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    done = 0;
    zd = 1'b0;
    do begin
      err = 0;
      for (int i = 0; i < n; i++) begin
        s = longint'(rhs_mem[i]) * 65536;
        for (int j = 0; j < n; j++) begin
          if (j != i) s = add_sat(s, -(longint'(coeff_mem[i*MAX_N+j]) * longint'(x_mem[j])));
        end
        dg = coeff_mem[i*MAX_N+i];
        xo = x_mem[i];
        if (dg == 0) begin
          zd = 1'b1;  // keep x_i, residual still counts
        end else begin
          q = quot_q16(s, dg);
          step = (longint'(q) - longint'(xo)) * longint'(omega_q);
          x_mem[i] = clamp32(longint'(xo) + longint'(to_q16(step)));
        end
        r64 = add_sat(s, -(longint'(dg) * longint'(xo)));
        r = to_q16(r64);
        mr = (r < 0) ? 64'd0 - longint'(unsigned'(longint'(r))) : longint'(unsigned'(longint'(r)));
        sq = mr * mr;
        err = (err > ~64'd0 - sq) ? ~64'd0 : err + sq;
      end
      done++;
    end while (err > {1'b0, tol_q} && done < sweep_cap_q);
    for (int i = 0; i < n; i++) begin
      w.index = i[3:0];
      w.solution = x_mem[i];
      w.last = (i + 1 == n);
      w.residual = err;
      w.sweeps_done = done[15:0];
      w.zero_diagonal = zd;
      solution_fifo.push_back(w);
    end
  endtask

  task automatic compare_word(input out_word_t got);
    out_word_t want;
    words_seen_o++;
    if (solution_fifo.size() == 0) begin
      report("unexpected out word index", got.index, 0);
      return;
    end
    want = solution_fifo.pop_front();
    if (got.index !== want.index) report("index", got.index, want.index);
    if (got.solution !== want.solution) report("solution", got.solution, want.solution);
    if (got.last !== want.last) report("last", got.last, want.last);
    if (got.residual !== want.residual) report("residual", got.residual, want.residual);
    if (got.sweeps_done !== want.sweeps_done)
      report("sweeps_done", got.sweeps_done, want.sweeps_done);
    if (got.zero_diagonal !== want.zero_diagonal)
      report("zero_diagonal", got.zero_diagonal, want.zero_diagonal);
  endtask

  initial begin
    fail_count_o = 0;
    words_seen_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q = 5'd16;
      tol_q = '0;
      omega_q = 18'd65536;
      sweep_cap_q = 16'd10000;
      solution_fifo.delete();
      for (int i = 0; i < MAX_N*MAX_N; i++) coeff_mem[i] = 0;
      for (int i = 0; i < MAX_N; i++) begin
        rhs_mem[i] = 0;
        x_mem[i] = 0;
      end
    end else begin
      if (out_valid_i && !out_stall_i) compare_word(out_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIZE:  size_q = cfg_data_i[4:0];
          REG_TOL:   tol_q = cfg_data_i[62:0];
          REG_OMEGA: omega_q = cfg_data_i[17:0];
          REG_MAXSW: sweep_cap_q = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.kind)
          KIND_MAT:   coeff_mem[in_data_i.row*MAX_N+in_data_i.col] = in_data_i.value;
          KIND_RHS:   rhs_mem[in_data_i.row] = in_data_i.value;
          KIND_GUESS: x_mem[in_data_i.row] = in_data_i.value;
          default:    solve_system();
        endcase
      end
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the SOR solver
// Loads systems of many sizes, runs solves under varied relaxation, tolerance
// and sweep limits, and leaves prediction and comparison to sor_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import sor_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int ITEM_TARGET = 370;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;

  int fail_count, pending, words_seen;
  int cycle_count = 0;
  int items_sent = 0;
  int solves = 0;
  int max_n_seen = 0;

  // which store entries hold a written value; a solve may only read those
  bit coeff_set [MAX_N*MAX_N];
  bit rhs_set   [MAX_N];
  bit x_set     [MAX_N];

  sor_linear_solver DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sor_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .words_seen_o(words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung solve or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("sor_linear_solver verification failed");
      $finish;
    end
  end

  // Receiver back-pressure: stall about 12 percent of the time, with a quiet
  // window early on where every out word is taken at once.
  always @(negedge clk) begin
    if (!rst_n || (cycle_count > 3000 && cycle_count < 40000)) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 12);
  end

  // Value mix: mostly small Q16.16 numbers, some full range, some corners.
  function automatic logic [31:0] pick_value(input bit tame);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (tame || sel < 70) return $urandom_range(0, 32'h80000) - 32'h40000;
    if (sel < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Hand one word over; hold it until it is taken. Idle in front of it at
  // random, except through a stretch in the middle of the run. Valid stays
  // up after the handover so that words can follow back to back.
  task automatic send(input logic [1:0] kind, input int row, input int col,
                      input logic [31:0] value);
    if (items_sent < 150 || items_sent > 240) begin
      while ($urandom_range(0, 99) < 12) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data.kind <= kind;
    in_data.row <= row[3:0];
    in_data.col <= col[3:0];
    in_data.value <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
    case (kind)
      KIND_MAT:   coeff_set[row*MAX_N+col] = 1'b1;
      KIND_RHS:   rhs_set[row] = 1'b1;
      KIND_GUESS: x_set[row] = 1'b1;
      default:    solves++;
    endcase
  endtask

  task automatic start_solve();
    send(KIND_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
  endtask

  // Drain: hold the sender until every predicted word is back, then let the
  // solver settle before touching registers.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_system(input int n, input bit tame);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) send(KIND_MAT, r, c, pick_value(tame));
      send(KIND_RHS, r, $urandom_range(0, 15), pick_value(tame));
      send(KIND_GUESS, r, $urandom_range(0, 15), pick_value(tame));
    end
  endtask

  function automatic bit system_ready(input int n);
    for (int r = 0; r < n; r++) begin
      if (!rhs_set[r] || !x_set[r]) return 1'b0;
      for (int c = 0; c < n; c++) if (!coeff_set[r*MAX_N+c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    int          raw_n, n, sweeps;
    bit          tame;
    logic [62:0] tol;
    logic [17:0] omega;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a 2x2 system with corner values, then a zero diagonal.
    cfg_write(REG_SIZE, 63'd2);
    cfg_write(REG_TOL, 63'd0);
    cfg_write(REG_OMEGA, 63'd65536);
    cfg_write(REG_MAXSW, 63'd3);
    send(KIND_MAT, 0, 0, 32'h7FFF_FFFF);
    send(KIND_MAT, 0, 1, 32'h8000_0000);
    send(KIND_MAT, 1, 0, 32'hFFFF_0000);
    send(KIND_MAT, 1, 1, 32'h0002_0000);
    send(KIND_RHS, 0, 15, 32'h8000_0000);
    send(KIND_RHS, 1, 0, 32'h7FFF_FFFF);
    send(KIND_GUESS, 0, 15, 32'h0000_0000);
    send(KIND_GUESS, 1, 0, 32'hFFFF_FFFF);
    send(KIND_START, 15, 15, 32'hFFFF_FFFF);
    send(KIND_MAT, 1, 1, 32'h0000_0000);
    send(KIND_GUESS, 0, 0, 32'h0001_8000);
    send(KIND_START, 0, 0, 32'h0000_0000);
    send(KIND_MAT, 1, 1, 32'h0003_0000);
    send(KIND_MAT, 0, 0, 32'h0004_0000);
    send(KIND_START, 5, 10, 32'h5A5A_A5A5);
    wait_drained();

    // Random phases: fresh registers, a reloaded or partly rewritten system, one to three solves.
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      case ($urandom_range(0, 19))
        0:       raw_n = 0;
        1:       raw_n = 16;
        2:       raw_n = $urandom_range(17, 31);
        3, 4:    raw_n = $urandom_range(5, 15);
        default: raw_n = $urandom_range(1, 4);
      endcase
      n = (raw_n < 1) ? 1 : (raw_n > MAX_N) ? MAX_N : raw_n;
      // keep the last phases small so the word count stays near the target
      if (items_sent + n*(n+2) > ITEM_TARGET + 20) begin
        raw_n = $urandom_range(1, 2);
        n = raw_n;
      end
      if (n > max_n_seen) max_n_seen = n;
      tame = 1'b0;
      case ($urandom_range(0, 3))
        0:       tol = 63'd0;
        1:       tol = 63'({$urandom, $urandom} >> 1);
        2:       tol = 63'($urandom_range(0, 32'hFFFFF));
        default: tol = 63'h7FFF_FFFF_FFFF_FFFF;
      endcase
      case ($urandom_range(0, 5))
        0:       omega = 18'd0;
        1:       omega = 18'd131072;
        2:       omega = 18'h3FFFF;
        3:       omega = 18'($urandom_range(0, 131072));
        default: omega = 18'd65536;
      endcase
      // Long sweep limits only on a 1x1 system, where the loose tolerance
      // always stops after one sweep.
      if (n == 1 && $urandom_range(0, 3) == 0) begin
        sweeps = 65535;
        tol = 63'h7FFF_FFFF_FFFF_FFFF;
        tame = 1'b1;
      end else if (n > 8) sweeps = $urandom_range(0, 2);
      else sweeps = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
      cfg_write(REG_MAXSW, 63'(sweeps));
      cfg_write(REG_OMEGA, 63'(omega));
      cfg_write(REG_TOL, tol);
      cfg_write(REG_SIZE, 63'(raw_n));
      if (tame || !system_ready(n) || $urandom_range(0, 9) < 4) load_system(n, tame);
      else repeat ($urandom_range(1, 4))
        send(KIND_MAT, $urandom_range(0, n-1), $urandom_range(0, n-1), pick_value(1'b0));
      // sometimes one load outside the active size, harmless to the solve
      if (n < MAX_N && $urandom_range(0, 3) == 0)
        send(KIND_RHS, $urandom_range(n, MAX_N-1), $urandom_range(0, 15), $urandom);
      repeat ($urandom_range(1, 3)) begin
        start_solve();
        if (!tame) send(KIND_GUESS, $urandom_range(0, n-1), $urandom_range(0, 15), pick_value(1'b0));
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("ran %0d input words and %0d solves, largest system %0dx%0d",
             items_sent, solves, max_n_seen, max_n_seen);
    $display("checked %0d solution words, %0d mismatches", words_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("sor_linear_solver verification clean");
    end else begin
      $display("sor_linear_solver verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/sor_pkg.sv
src/sor_divider.sv
src/sor_linear_solver.sv
src/sor_checker.sv
bench/sor_checker.sv
bench/tb_top.sv
